### rtl/dtte_pkg.sv
// Shared types, constants and helper functions for the date-time text converter.
`default_nettype none

package dtte_pkg;

   localparam int OffsetWidth = 17;
   localparam int DaysWidth   = 16;
   localparam int SodWidth    = 17;
   localparam int EpochWidth  = 33;

   localparam logic signed [19:0] YearMin    = 20'sd1970;
   localparam logic signed [19:0] YearMax    = 20'sd2100;
   localparam logic [7:0]         LengthMin  = 8'd19;
   localparam logic signed [OffsetWidth-1:0] OffsetReset = 17'sd18000;

   localparam logic signed [20:0] DaysPerEra    = 21'sd146097;
   localparam logic signed [20:0] EpochDayShift = 21'sd719468;
   localparam logic [16:0]        SecondsPerDay = 17'd86400;

   typedef logic signed [8:0]  digit_type;
   typedef logic signed [12:0] pair_type;
   typedef logic signed [19:0] year_type;

   typedef struct packed {
      logic                 ok;
      logic [DaysWidth-1:0] days;
      logic [SodWidth-1:0]  sod;
   } date_type;

   function automatic digit_type digit_value(input logic [7:0] ch);
      return $signed({1'b0, ch}) - 9'sd48;
   endfunction

   function automatic pair_type pair_value(input logic [15:0] text);
      return 13'(digit_value(text[15:8])) * 13'sd10 + 13'(digit_value(text[7:0]));
   endfunction

   function automatic year_type year_value(input logic [31:0] text);
      return 20'(digit_value(text[31:24])) * 20'sd1000 +
             20'(digit_value(text[23:16])) * 20'sd100 +
             20'(digit_value(text[15:8])) * 20'sd10 +
             20'(digit_value(text[7:0]));
   endfunction

   // Days from March 1 to the first day of the month, for the March-based month index.
   function automatic logic [8:0] days_before_month(input logic [3:0] m);
      logic [8:0] d;
      case (m)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd61;
         4'd3:    d = 9'd92;
         4'd4:    d = 9'd122;
         4'd5:    d = 9'd153;
         4'd6:    d = 9'd184;
         4'd7:    d = 9'd214;
         4'd8:    d = 9'd245;
         4'd9:    d = 9'd275;
         4'd10:   d = 9'd306;
         4'd11:   d = 9'd337;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

### rtl/dtte_days.sv
// Digit decode, range checks, civil-date to day-number conversion and seconds of the day.
`default_nettype none

module dtte_days
   import dtte_pkg::*;
(
   input  wire logic [7:0]  text_length,
   input  wire logic [31:0] year_text,
   input  wire logic [15:0] month_text,
   input  wire logic [15:0] day_text,
   input  wire logic [15:0] hour_text,
   input  wire logic [15:0] minute_text,
   input  wire logic [15:0] second_text,
   output date_type         date
);

   year_type          year;
   pair_type          month;
   pair_type          day;
   pair_type          hour;
   pair_type          minute;
   pair_type          second;
   logic              early;
   year_type          y_full;
   logic [11:0]       y;
   logic              era5;
   logic [8:0]        yoe;
   logic [1:0]        yoe_cent;
   logic [3:0]        m;
   logic [8:0]        doy;
   logic [17:0]       doe;
   logic signed [20:0] days_full;

   always_comb begin
      year   = year_value(year_text);
      month  = pair_value(month_text);
      day    = pair_value(day_text);
      hour   = pair_value(hour_text);
      minute = pair_value(minute_text);
      second = pair_value(second_text);

      date.ok = (text_length >= LengthMin) &&
                (year >= YearMin) && (year <= YearMax) &&
                (month >= 13'sd1) && (month <= 13'sd12) &&
                (day >= 13'sd1) && (day <= 13'sd31) &&
                (hour >= 13'sd0) && (hour <= 13'sd23) &&
                (minute >= 13'sd0) && (minute <= 13'sd59) &&
                (second >= 13'sd0) && (second <= 13'sd59);

      early  = (month <= 13'sd2);
      y_full = year - 20'(early);
      y      = y_full[11:0];
      m      = early ? 4'(month[3:0] + 4'd9) : 4'(month[3:0] - 4'd3);
      era5   = (y >= 12'd2000);
      yoe    = 9'(y - (era5 ? 12'd2000 : 12'd1600));

      if (yoe >= 9'd300) begin
         yoe_cent = 2'd3;
      end else if (yoe >= 9'd200) begin
         yoe_cent = 2'd2;
      end else if (yoe >= 9'd100) begin
         yoe_cent = 2'd1;
      end else begin
         yoe_cent = 2'd0;
      end

      doy = days_before_month(m) + 9'(day[4:0]) - 9'd1;
      doe = 18'(yoe) * 18'd365 + 18'(yoe[8:2]) - 18'(yoe_cent) + 18'(doy);
      days_full = (era5 ? DaysPerEra * 21'sd5 : DaysPerEra * 21'sd4) +
                  $signed({3'b000, doe}) - EpochDayShift;
      date.days = days_full[DaysWidth-1:0];
      date.sod  = 17'(hour[4:0]) * 17'd3600 + 17'(minute[5:0]) * 17'd60 +
                  17'(second[5:0]);
   end

endmodule

`default_nettype wire

### rtl/dtte_scale.sv
// Scales the day number to seconds and adds time of day and the zone offset.
`default_nettype none

module dtte_scale
   import dtte_pkg::*;
(
   input  wire date_type                        date,
   input  wire logic signed [OffsetWidth-1:0]   zone_offset,
   output logic signed [EpochWidth-1:0]         epoch
);

   logic [31:0]        day_secs;
   logic signed [33:0] total;

   always_comb begin
      day_secs = 32'(date.days) * 32'(SecondsPerDay);
      total    = $signed({2'b00, day_secs}) + $signed({17'b0, date.sod}) +
                 34'(zone_offset);
      epoch    = date.ok ? total[EpochWidth-1:0] : '0;
   end

endmodule

`default_nettype wire

### rtl/datetime_text_to_epoch_seconds.sv
// Top level of the date-time text to Unix epoch seconds converter.
// Each request carries the ASCII digits of a "YYYY-MM-DD HH:MM:SS" text and its length,
// and yields one response with a valid flag and signed epoch seconds including the zone
// offset (0 when invalid). Requests flow through three register stages: input capture,
// day-number conversion, and the multiply-add into the response register, and one
// request is accepted in every cycle while the response side is not stalled. The zone
// offset register resets to 18000 and must be written only while idle.
`default_nettype none

module datetime_text_to_epoch_seconds
   import dtte_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire logic signed [OffsetWidth-1:0] csr_write_data,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [7:0]                    req_text_length,
   input  wire logic [31:0]                   req_year_text,
   input  wire logic [15:0]                   req_month_text,
   input  wire logic [15:0]                   req_day_text,
   input  wire logic [15:0]                   req_hour_text,
   input  wire logic [15:0]                   req_minute_text,
   input  wire logic [15:0]                   req_second_text,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_time_valid,
   output logic signed [EpochWidth-1:0]       rsp_epoch_seconds
);

   logic signed [OffsetWidth-1:0] zone_offset_ff;
   logic                          advance;

   logic        in_valid_ff;
   logic [7:0]  length_ff;
   logic [31:0] year_ff;
   logic [15:0] month_ff;
   logic [15:0] day_ff;
   logic [15:0] hour_ff;
   logic [15:0] minute_ff;
   logic [15:0] second_ff;

   date_type    date_in;
   date_type    date_ff;
   logic        date_valid_ff;

   logic signed [EpochWidth-1:0] epoch_in;
   logic                         rsp_valid_ff;
   logic                         rsp_time_valid_ff;
   logic signed [EpochWidth-1:0] rsp_epoch_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_offset_ff <= OffsetReset;
      end else if (csr_write_enable) begin
         zone_offset_ff <= csr_write_data;
      end
   end

   dtte_days u_days (
      .text_length (length_ff),
      .year_text   (year_ff),
      .month_text  (month_ff),
      .day_text    (day_ff),
      .hour_text   (hour_ff),
      .minute_text (minute_ff),
      .second_text (second_ff),
      .date        (date_in)
   );

   dtte_scale u_scale (
      .date        (date_ff),
      .zone_offset (zone_offset_ff),
      .epoch       (epoch_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         date_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         in_valid_ff   <= req_valid;
         date_valid_ff <= in_valid_ff;
         rsp_valid_ff  <= date_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         length_ff         <= req_text_length;
         year_ff           <= req_year_text;
         month_ff          <= req_month_text;
         day_ff            <= req_day_text;
         hour_ff           <= req_hour_text;
         minute_ff         <= req_minute_text;
         second_ff         <= req_second_text;
         date_ff           <= date_in;
         rsp_time_valid_ff <= date_ff.ok;
         rsp_epoch_ff      <= epoch_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_time_valid    = rsp_time_valid_ff;
   assign rsp_epoch_seconds = rsp_epoch_ff;

endmodule

`default_nettype wire
